// File: design/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; used by lph_mod and linear_probe_hash_table.
package lph_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_W        = 31;
   localparam int CFG_W        = 11;
   localparam int SLOT_W       = 10;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [1:0] REG_TABLE_SIZE = 2'd0;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_ACTIVE  = 2'd1;
   localparam logic [1:0] MARK_REMOVED = 2'd2;

   typedef struct packed {
      logic [1:0]       mark;
      logic [KEY_W-1:0] key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_RESP
   } state_type;

endpackage

// File: design/lph_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lph_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lph_mod.sv
// Iterative key modulo table size: restoring remainder, two bits per cycle.
// Depends on lph_pkg (key width).
module lph_mod #(
   parameter int DIV_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [lph_pkg::KEY_W-1:0] dividend,
   input  logic [DIV_W-1:0]        divisor,
   output logic                    done,
   output logic [DIV_W-1:0]        remainder
);

   import lph_pkg::*;

   localparam int STEPS = 2;
   localparam int PAD_W = ((KEY_W + STEPS - 1) / STEPS) * STEPS;
   localparam int ITER  = PAD_W / STEPS;
   localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
   localparam int REM_W = DIV_W + 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAD_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;

   always_comb begin
      logic [REM_W-1:0] t;
      logic [PAD_W-1:0] q;
      t = rem_ff;
      q = quo_ff;
      for (int i = 0; i < STEPS; i++) begin
         t = {t[DIV_W-1:0], q[PAD_W-1]};
         q = {q[PAD_W-2:0], 1'b0};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = PAD_W'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = q;
         rem_in = t;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DIV_W-1:0];

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, done_ff, rem_ff < {1'b0, divisor}, "remainder not below divisor")
   `ASSERT_IMPLIES(a_no_start_busy, clock, reset, start, !busy_ff, "modulo restarted while busy")

endmodule

// File: design/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing; slot state in one RAM.
// Depends on lph_pkg, lph_ram, lph_mod and assert_macros.svh.
//
// Use: a request transaction carries an operation on req_tuser (insert, find,
// remove) and a 31-bit key on req_tdata. Each request yields one response
// transaction: req success on rsp_tuser[0] and the slot index on rsp_tdata.
// table_size is written through the csr_ APB port at address 0; a write
// clears the table and reads return the size in use.
// Flow: one request at a time. After acceptance the home slot is computed
// in the two-bit-per-cycle modulo unit, then the RAM is probed one slot per
// cycle (registered read), and the result is queued for the response.
// An insert into a full table or an unused operation code skips the modulo
// unit and the probing.
// The response sits in an output register; the next request is taken while
// it waits, and a stalled receiver only holds up the end of the following
// operation.
// Reset and every table_size write start a clearing pass over the first
// table_size entries (CAPACITY after reset), one RAM entry per cycle, during
// which req_tready is low. CSR writes are taken at any time.
module linear_probe_hash_table #(
   parameter int CAPACITY = lph_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // [30:0] key
   input  logic [1:0]                     req_tuser,  // [1:0] operation
   // response
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,  // [9:0] slot
   output logic                           rsp_tuser,  // [0] success
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lph_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   import lph_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int SIZE_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic              cfg_hit;
   logic [31:0]       cfg_size;
   logic [SIZE_W-1:0] new_size;
   logic              req_acc;
   logic              fast_fail;
   logic              clr_last;
   logic              rsp_free;

   logic               ram_wr, ram_re;
   logic [IDX_W-1:0]   ram_wa, ram_ra;
   logic [ENTRY_W-1:0] ram_wd, ram_rd;
   entry_type          ent, chk_ent;

   logic               mod_start, mod_done;
   logic [SIZE_W-1:0]  mod_rem;
   logic [IDX_W-1:0]   rem_idx;

   logic [SIZE_W-1:0]  pos_p1;
   logic [IDX_W-1:0]   nxt;
   logic               probe_last;
   logic               chk_end, chk_ok, chk_wr;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(size_ff);
   assign cfg_hit = csr_psel & csr_penable & csr_pwrite & csr_pready &
                    (csr_paddr[3:2] == REG_TABLE_SIZE);

   always_comb begin
      cfg_size = 32'(csr_pwdata[CFG_W-1:0]);
      if (cfg_size == 32'd0) begin
         cfg_size = 32'd1;
      end
      if (cfg_size > 32'(CAPACITY)) begin
         cfg_size = 32'(CAPACITY);
      end
   end
   assign new_size = SIZE_W'(cfg_size);

   // ---------------- datapath helpers ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign fast_fail  = ((req_tuser == OP_INSERT) && (free_ff == '0)) ||
                       ((req_tuser != OP_INSERT) && (req_tuser != OP_FIND) &&
                        (req_tuser != OP_REMOVE));
   assign clr_last   = (SIZE_W'(clr_ff) == size_ff - SIZE_W'(1));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rem_idx    = IDX_W'(mod_rem);

   assign ent        = entry_type'(ram_rd);
   assign pos_p1     = SIZE_W'(pos_ff) + SIZE_W'(1);
   assign nxt        = (pos_p1 >= size_ff) ? '0 : IDX_W'(pos_p1);
   assign probe_last = (SIZE_W'(cnt_ff) == size_ff - SIZE_W'(1));

   // Probe decision on the entry just read.
   always_comb begin
      chk_end = 1'b0;
      chk_ok  = 1'b0;
      chk_wr  = 1'b0;
      chk_ent = ent;
      case (op_ff) inside
         OP_INSERT: begin
            if (ent.mark != MARK_ACTIVE) begin
               chk_end      = 1'b1;
               chk_ok       = 1'b1;
               chk_wr       = 1'b1;
               chk_ent.mark = MARK_ACTIVE;
               chk_ent.key  = key_ff;
            end else if (probe_last) begin
               chk_end = 1'b1;
            end
         end
         OP_FIND, OP_REMOVE: begin
            if (ent.mark == MARK_EMPTY) begin
               chk_end = 1'b1;
            end else if ((ent.mark == MARK_ACTIVE) && (ent.key == key_ff)) begin
               chk_end = 1'b1;
               chk_ok  = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  chk_wr       = 1'b1;
                  chk_ent.mark = MARK_REMOVED;
               end
            end else if (nxt == home_ff) begin
               chk_end = 1'b1;
            end
         end
         default: begin
            chk_end = 1'b1;
         end
      endcase
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      if (cfg_hit) begin
         state_in = ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: if (clr_last) state_in = ST_IDLE;
            ST_IDLE: begin
               if (req_acc) begin
                  state_in = fast_fail ? ST_RESP : ST_MOD;
               end
            end
            ST_MOD:   if (mod_done) state_in = ST_CHECK;
            ST_CHECK: if (chk_end) state_in = ST_RESP;
            ST_RESP:  if (rsp_free) state_in = ST_IDLE;
            default:  state_in = ST_CLEAR;
         endcase
      end
   end

   // ---------------- outputs and datapath ----------------
   always_comb begin
      size_in      = size_ff;
      free_in      = free_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      home_in      = home_ff;
      cnt_in       = cnt_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      ram_wr       = 1'b0;
      ram_wa       = clr_ff;
      ram_wd       = ENTRY_W'({MARK_EMPTY, {KEY_W{1'b0}}});
      ram_re       = 1'b0;
      ram_ra       = pos_ff;
      mod_start    = 1'b0;

      if (cfg_hit) begin
         size_in = new_size;
         free_in = new_size;
         clr_in  = '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               ram_wr = 1'b1;
               clr_in = clr_ff + IDX_W'(1);
            end
            ST_IDLE: begin
               if (req_acc) begin
                  op_in       = req_tuser;
                  key_in      = req_tdata[KEY_W-1:0];
                  res_ok_in   = 1'b0;
                  res_slot_in = '0;
                  mod_start   = !fast_fail;
               end
            end
            ST_MOD: begin
               if (mod_done) begin
                  ram_re  = 1'b1;
                  ram_ra  = rem_idx;
                  pos_in  = rem_idx;
                  home_in = rem_idx;
                  cnt_in  = '0;
               end
            end
            ST_CHECK: begin
               if (chk_end) begin
                  res_ok_in   = chk_ok;
                  res_slot_in = chk_ok ? SLOT_W'(pos_ff) : '0;
                  if (chk_wr) begin
                     ram_wr = 1'b1;
                     ram_wa = pos_ff;
                     ram_wd = ENTRY_W'(chk_ent);
                  end
                  if (chk_ok && (op_ff == OP_INSERT)) begin
                     free_in = free_ff - SIZE_W'(1);
                  end
                  if (chk_ok && (op_ff == OP_REMOVE) && (free_ff < size_ff)) begin
                     free_in = free_ff + SIZE_W'(1);
                  end
               end else begin
                  ram_re = 1'b1;
                  ram_ra = nxt;
                  pos_in = nxt;
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = res_ok_ff;
                  rsp_slot_in  = res_slot_ff;
               end
            end
            default: begin
               clr_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= SIZE_W'(CAPACITY);
         free_ff      <= SIZE_W'(CAPACITY);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      home_ff     <= home_in;
      cnt_ff      <= cnt_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = 16'(rsp_slot_ff);

   // ---------------- submodules ----------------
   lph_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   lph_mod #(
      .DIV_W (SIZE_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (key_in),
      .divisor   (size_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_free_le_size, clock, reset, free_ff <= size_ff, "free count above table size")
   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !ram_wr, "RAM written while idle")
   `ASSERT_IMPLIES(a_probe_in_range, clock, reset, state_ff == ST_CHECK, SIZE_W'(pos_ff) < size_ff, "probe beyond table size")
   `ASSERT_IMPLIES(a_fail_slot_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_slot_ff == '0, "failed response with nonzero slot")

endmodule

// File: bench/tb_linear_probe_hash_table.sv
// Self-checking testbench for linear_probe_hash_table: insert, find and remove
// traffic over several table sizes, checked against a shadow copy of the table.
// Depends on lph_pkg and the linear_probe_hash_table RTL.
module tb_linear_probe_hash_table;
   timeunit 1ns;
   timeprecision 1ps;

   import lph_pkg::*;

   localparam int          CAPACITY    = CAPACITY_DEF;
   localparam int          CYCLE_LIMIT = 2_000_000;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;  // undefined operation code
   localparam logic [1:0]  REG_UNUSED  = 2'd1;  // no register at this index

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } hash_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;
   logic [1:0]            req_tuser   = OP_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b1;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow of the table contents
   logic [KEY_W-1:0] shadow_keys  [0:CAPACITY-1];
   logic [1:0]       shadow_marks [0:CAPACITY-1];
   int unsigned      shadow_free;
   int unsigned      shadow_size;

   hash_result_type pending_results[$];
   hash_result_type oldest;

   int  error_count  = 0;
   int  cycle_count  = 0;
   int  req_count    = 0;
   int  rsp_count    = 0;
   int  hit_count    = 0;
   int  size_writes  = 0;
   int  stall_left   = 0;
   int  stall_draw;
   bit  no_idle      = 1'b0;

   linear_probe_hash_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [30:0] key
      .req_tuser   (req_tuser),    // [1:0] operation
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [9:0] slot
      .rsp_tuser   (rsp_tuser),    // [0] success
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH (cycle %0d): %s", cycle_count, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic void apply_table_size(input logic [31:0] value);
      int unsigned v;
      v = value[CFG_W-1:0];
      if (v == 0) v = 1;
      if (v > CAPACITY) v = CAPACITY;
      shadow_size = v;
      shadow_free = v;
      foreach (shadow_marks[i]) shadow_marks[i] = MARK_EMPTY;
   endfunction

   function automatic int unsigned next_probe(input int unsigned pos);
      return (pos + 1 >= shadow_size) ? 0 : pos + 1;
   endfunction

   // probe from home until an empty slot, a matching key or back at home
   function automatic bit locate_key(input int unsigned key, output int unsigned where);
      int unsigned home;
      int unsigned pos;
      int unsigned n;
      home  = key % shadow_size;
      pos   = home;
      where = 0;
      for (n = 0; n < shadow_size; n++) begin
         if (shadow_marks[pos] == MARK_EMPTY) return 1'b0;
         if (shadow_marks[pos] == MARK_ACTIVE && shadow_keys[pos] == key) begin
            where = pos;
            return 1'b1;
         end
         pos = next_probe(pos);
         if (pos == home) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic hash_result_type predict_hash_op(input logic [1:0] op,
                                                       input logic [KEY_W-1:0] key);
      hash_result_type r;
      int unsigned     k;
      int unsigned     pos;
      int unsigned     n;
      bit              hit;
      k   = key;
      pos = 0;
      hit = 1'b0;
      case (op)
         OP_INSERT: begin
            if (shadow_free != 0) begin
               pos = k % shadow_size;
               n   = 0;
               while (n < shadow_size && shadow_marks[pos] == MARK_ACTIVE) begin
                  pos = next_probe(pos);
                  n++;
               end
               // no duplicate check: first empty or removed slot wins
               if (shadow_marks[pos] != MARK_ACTIVE) begin
                  shadow_keys[pos]  = key;
                  shadow_marks[pos] = MARK_ACTIVE;
                  shadow_free--;
                  hit = 1'b1;
               end
            end
         end
         OP_FIND: begin
            hit = locate_key(k, pos);
         end
         OP_REMOVE: begin
            hit = locate_key(k, pos);
            if (hit) begin
               shadow_marks[pos] = MARK_REMOVED;
               if (shadow_free < shadow_size) shadow_free++;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      r.ok   = hit;
      r.slot = hit ? pos[SLOT_W-1:0] : '0;
      return r;
   endfunction

   // ----------------------------------------------------------- drivers

   // called from a rising-edge time step; leaves req_tvalid high on return
   task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, key};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_hash_op(op, key));
      req_count++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      wait_drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_TABLE_SIZE) begin
         apply_table_size(data);
         size_writes++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_size();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {REG_TABLE_SIZE, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== shadow_size)
         report_mismatch($sformatf("table_size read %0d, expected %0d",
                                   csr_prdata, shadow_size));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------ response check and backpressure

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left  = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (rsp_tuser) hit_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response ok=%0b slot=%0d",
                                      rsp_tuser, rsp_tdata));
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tuser !== oldest.ok || rsp_tdata !== {6'b0, oldest.slot})
               report_mismatch($sformatf(
                  "response %0d: got ok=%0b slot=%0d, expected ok=%0b slot=%0d",
                  rsp_count, rsp_tuser, rsp_tdata, oldest.ok, oldest.slot));
         end
         stall_draw = no_idle ? 0 : $urandom_range(0, 7);
         if (stall_draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left  = stall_draw;
         end
      end else if (!rsp_tready) begin
         if (stall_left <= 1) rsp_tready <= 1'b1;
         else stall_left--;
      end
   end

   // ----------------------------------------------------------------- tests

   // full-size table after reset: key extremes, wrap at the top slot, tombstones
   task automatic test_reset_extremes();
      csr_check_size();
      send_request(OP_INSERT, '0);
      send_request(OP_INSERT, 31'h7FFF_FFFF);
      send_request(OP_INSERT, 31'h7FFF_FFFF);   // duplicate wraps past slot 0
      send_request(OP_FIND,   31'h7FFF_FFFF);
      send_request(OP_FIND,   31'd5);
      send_request(OP_UNUSED, 31'h7FFF_FFFF);
      send_request(OP_REMOVE, '0);
      send_request(OP_FIND,   '0);              // probes across the tombstone
      send_request(OP_REMOVE, '0);              // already gone
      wait_drain();
   endtask

   // tiny table: fill it, overflow, absent lookup wraps, tombstone reuse
   task automatic test_full_table();
      csr_write(REG_TABLE_SIZE, 32'd3);
      csr_check_size();
      send_request(OP_INSERT, 31'd3);
      send_request(OP_INSERT, 31'd6);
      send_request(OP_INSERT, 31'd9);
      send_request(OP_INSERT, 31'd12);
      send_request(OP_FIND,   31'd100);
      send_request(OP_REMOVE, 31'd6);
      send_request(OP_INSERT, 31'd12);
      send_request(OP_FIND,   31'd12);
      wait_drain();
   endtask

   // size zero and oversize writes, unknown register, upper data bits ignored
   task automatic test_size_edges();
      csr_write(REG_TABLE_SIZE, 32'd0);
      csr_check_size();
      send_request(OP_INSERT, 31'd5);
      send_request(OP_INSERT, 31'd7);
      csr_write(REG_TABLE_SIZE, 32'd2047);
      csr_check_size();
      send_request(OP_INSERT, 31'd2047);
      csr_write(REG_UNUSED, 32'd5);             // must not clear the table
      csr_check_size();
      send_request(OP_FIND,   31'd2047);
      csr_write(REG_TABLE_SIZE, 32'h0000_0805);
      csr_check_size();
      send_request(OP_FIND,   31'd2047);
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int unsigned      sizes [11] = '{1, 2, 3, 5, 7, 8, 13, 16, 29, 64, 1024};
      logic [KEY_W-1:0] key_pool[$];
      logic [KEY_W-1:0] key;
      logic [1:0]       op;
      logic [31:0]      upper;
      int               sel;
      int               pick;
      foreach (sizes[p]) begin
         key_pool.delete();
         upper = $urandom();
         csr_write(REG_TABLE_SIZE, {upper[31:CFG_W], sizes[p][CFG_W-1:0]});
         csr_check_size();
         for (int i = 0; i < 70; i++) begin
            if (i % 35 == 0) no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
               op   = OP_INSERT;
               pick = $urandom_range(0, 9);
               if (key_pool.size() == 0 || pick < 5)
                  key = KEY_W'($urandom());
               else if (pick < 8)  // same home slot as an earlier key
                  key = KEY_W'(key_pool[$urandom_range(0, key_pool.size() - 1)]
                               + sizes[p] * $urandom_range(1, 50));
               else
                  key = key_pool[$urandom_range(0, key_pool.size() - 1)];
               key_pool.push_back(key);
            end else begin
               op = (sel < 70) ? OP_FIND : (sel < 95) ? OP_REMOVE : OP_UNUSED;
               if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
                  key = key_pool[$urandom_range(0, key_pool.size() - 1)];
               else
                  key = KEY_W'($urandom());
            end
            send_request(op, key);
         end
      end
      no_idle = 1'b0;
      wait_drain();
   endtask

   initial begin
      apply_table_size(CAPACITY);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_extremes();
      test_full_table();
      test_size_edges();
      test_random_traffic();
      wait_drain();
      repeat (64) @(posedge clock);
      $display("Ran %0d requests, %0d responses (%0d successful), %0d size writes",
               req_count, rsp_count, hit_count, size_writes);
      $display("Sizes from 1 to %0d, full tables, tombstones and unused op codes",
               CAPACITY);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results outstanding",
                  error_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: linear_probe_hash_table.f
+incdir+design
design/lph_pkg.sv
design/lph_ram.sv
design/lph_mod.sv
design/linear_probe_hash_table.sv
bench/tb_linear_probe_hash_table.sv
